FILE: hw/rtl/hsl_pkg.sv
// ----------------------------------------------------------------------------
// hsl_pkg: shared types, widths and helpers for the HSL to RGB converter
// Fixed-point format: unsigned, FRAC_BITS fraction bits, 1.0 = 1 << FRAC_BITS.
// ----------------------------------------------------------------------------
package hsl_pkg;

    // Fixed-point format
    localparam int FRAC_BITS = 16;
    localparam int FIELD_W   = 17;
    localparam logic [FIELD_W-1:0] ONE  = FIELD_W'(1 << FRAC_BITS);
    localparam logic [FIELD_W-1:0] HALF = FIELD_W'(1 << (FRAC_BITS - 1));

    // Internal widths
    localparam int PROD_W  = 2 * FIELD_W;            // L*S product
    localparam int Q_W     = PROD_W - FRAC_BITS;     // L*S scaled back
    localparam int HUE6_W  = FIELD_W + 3;            // hue * 6
    localparam int SECT_W  = HUE6_W - FRAC_BITS;     // sector number
    localparam int VAL_W   = FIELD_W + 4;            // signed MX, MN, spread, ramp
    localparam int ACC_W   = VAL_W + 1;              // signed MN+ramp, MX-ramp
    localparam int RPROD_W = FRAC_BITS + 1 + VAL_W;  // frac * spread

    // Bias for truncation toward zero of a negative scaled product
    localparam logic signed [RPROD_W-1:0] TRUNC_BIAS = RPROD_W'((1 << FRAC_BITS) - 1);

    // Hue sectors (six times the hue, integer part)
    localparam logic [SECT_W-1:0] SEC_RED_GREEN_UP  = SECT_W'(0);
    localparam logic [SECT_W-1:0] SEC_RED_DOWN      = SECT_W'(1);
    localparam logic [SECT_W-1:0] SEC_BLUE_UP       = SECT_W'(2);
    localparam logic [SECT_W-1:0] SEC_GREEN_DOWN    = SECT_W'(3);
    localparam logic [SECT_W-1:0] SEC_RED_UP        = SECT_W'(4);
    localparam logic [SECT_W-1:0] SEC_BLUE_DOWN     = SECT_W'(5);
    localparam logic [SECT_W-1:0] SEC_FULL_TURN     = SECT_W'(6);

    // Input pixel
    typedef struct packed {
        logic [FIELD_W-1:0] hue;
        logic [FIELD_W-1:0] lightness;
        logic [FIELD_W-1:0] saturation;
    } pix_t;

    // Channel extremes and hue split
    typedef struct packed {
        logic signed [VAL_W-1:0] mx;
        logic signed [VAL_W-1:0] mn;
        logic signed [VAL_W-1:0] spread;
        logic [SECT_W-1:0]       sector;
        logic [FRAC_BITS-1:0]    frac;
        logic                    mx_pos;
    } ext_t;

    // Candidate channel values
    typedef struct packed {
        logic signed [ACC_W-1:0] mx;
        logic signed [ACC_W-1:0] mn;
        logic signed [ACC_W-1:0] up;
        logic signed [ACC_W-1:0] down;
        logic [SECT_W-1:0]       sector;
        logic                    mx_pos;
    } ramp_t;

    // Output pixel
    typedef struct packed {
        logic [FIELD_W-1:0] red;
        logic [FIELD_W-1:0] green;
        logic [FIELD_W-1:0] blue;
    } rgb_t;

    // Clamp a signed channel value to 0..1.0
    function automatic logic [FIELD_W-1:0] sat_channel(input logic signed [ACC_W-1:0] v);
        logic [FIELD_W-1:0] res;
        if (v < 0)
        begin
            res = '0;
        end
        else if (v > signed'(ACC_W'(ONE)))
        begin
            res = ONE;
        end
        else
        begin
            res = v[FIELD_W-1:0];
        end
        return res;
    endfunction

endpackage

FILE: hw/rtl/hsl_extreme.sv
// ----------------------------------------------------------------------------
// hsl_extreme: brightest/darkest channel and hue sector
// Stage A multiplies L*S and scales the hue by six; stage B forms MX, MN and
// the spread MX-MN from the product.
// ----------------------------------------------------------------------------
module hsl_extreme (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_ready,
    input  hsl_pkg::pix_t in_pix,
    output logic          out_valid,
    input  logic          out_ready,
    output hsl_pkg::ext_t out_ext
);
    import hsl_pkg::*;

    // Stage A registers
    logic                a_valid_reg;
    logic [PROD_W-1:0]   prod_reg;
    logic [PROD_W-1:0]   prod_next;
    logic [FIELD_W-1:0]  l_reg;
    logic [FIELD_W-1:0]  s_reg;
    logic                lhi_reg;
    logic                lhi_next;
    logic [HUE6_W-1:0]   hue6_reg;
    logic [HUE6_W-1:0]   hue6_next;
    logic                a_ready;

    // Stage B registers
    logic                b_valid_reg;
    ext_t                ext_reg;
    ext_t                ext_next;
    logic                b_ready;

    logic signed [VAL_W-1:0] ls;
    logic signed [VAL_W-1:0] ss;
    logic signed [VAL_W-1:0] qs;

    // Handshake: a stage loads when empty or when its successor takes its beat
    assign b_ready  = !b_valid_reg || out_ready;
    assign a_ready  = !a_valid_reg || b_ready;
    assign in_ready = a_ready;

    // Stage A: product and hue scaling
    assign prod_next = PROD_W'(in_pix.lightness) * PROD_W'(in_pix.saturation);
    assign lhi_next  = in_pix.lightness > HALF;
    assign hue6_next = (HUE6_W'(in_pix.hue) << 2) + (HUE6_W'(in_pix.hue) << 1);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
        end
        else if (a_ready)
        begin
            a_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (a_ready && in_valid)
        begin
            prod_reg <= prod_next;
            l_reg    <= in_pix.lightness;
            s_reg    <= in_pix.saturation;
            lhi_reg  <= lhi_next;
            hue6_reg <= hue6_next;
        end
    end

    // Stage B: MX = L+S-L*S (L above half) or L+L*S; MN = 2L-MX
    assign ls = signed'(VAL_W'(l_reg));
    assign ss = signed'(VAL_W'(s_reg));
    assign qs = signed'(VAL_W'(prod_reg[PROD_W-1:FRAC_BITS]));

    always_comb
    begin
        if (lhi_reg)
        begin
            ext_next.mx     = ls + ss - qs;
            ext_next.mn     = ls - ss + qs;
            ext_next.spread = (ss - qs) <<< 1;
        end
        else
        begin
            ext_next.mx     = ls + qs;
            ext_next.mn     = ls - qs;
            ext_next.spread = qs <<< 1;
        end
        ext_next.sector = hue6_reg[HUE6_W-1:FRAC_BITS];
        ext_next.frac   = hue6_reg[FRAC_BITS-1:0];
        ext_next.mx_pos = ext_next.mx > 0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b_valid_reg <= 1'b0;
        end
        else if (b_ready)
        begin
            b_valid_reg <= a_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (b_ready && a_valid_reg)
        begin
            ext_reg <= ext_next;
        end
    end

    assign out_valid = b_valid_reg;
    assign out_ext   = ext_reg;

endmodule

FILE: hw/rtl/hsl_ramp.sv
// ----------------------------------------------------------------------------
// hsl_ramp: hue ramp and rising/falling channel values
// Stage C multiplies the hue fraction by the spread; stage D scales it back
// with truncation toward zero and forms MN+ramp and MX-ramp.
// ----------------------------------------------------------------------------
module hsl_ramp (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_ready,
    input  hsl_pkg::ext_t  in_ext,
    output logic           out_valid,
    input  logic           out_ready,
    output hsl_pkg::ramp_t out_ramp
);
    import hsl_pkg::*;

    // Stage C registers
    logic                      c_valid_reg;
    logic signed [RPROD_W-1:0] rprod_reg;
    logic signed [RPROD_W-1:0] rprod_next;
    logic signed [VAL_W-1:0]   mx_reg;
    logic signed [VAL_W-1:0]   mn_reg;
    logic [SECT_W-1:0]         sector_reg;
    logic                      mx_pos_reg;
    logic                      c_ready;
    logic signed [FRAC_BITS:0] frac_s;

    // Stage D registers
    logic                      d_valid_reg;
    ramp_t                     ramp_reg;
    ramp_t                     ramp_next;
    logic                      d_ready;
    logic signed [RPROD_W-1:0] biased;
    logic signed [VAL_W-1:0]   ramp;

    assign d_ready  = !d_valid_reg || out_ready;
    assign c_ready  = !c_valid_reg || d_ready;
    assign in_ready = c_ready;

    // Stage C: fraction times spread
    assign frac_s     = signed'({1'b0, in_ext.frac});
    assign rprod_next = frac_s * in_ext.spread;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            c_valid_reg <= 1'b0;
        end
        else if (c_ready)
        begin
            c_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (c_ready && in_valid)
        begin
            rprod_reg  <= rprod_next;
            mx_reg     <= in_ext.mx;
            mn_reg     <= in_ext.mn;
            sector_reg <= in_ext.sector;
            mx_pos_reg <= in_ext.mx_pos;
        end
    end

    // Stage D: scale back toward zero, then rising and falling values
    assign biased = rprod_reg + (rprod_reg[RPROD_W-1] ? TRUNC_BIAS : '0);
    assign ramp   = signed'(biased[FRAC_BITS +: VAL_W]);

    always_comb
    begin
        ramp_next.mx     = ACC_W'(mx_reg);
        ramp_next.mn     = ACC_W'(mn_reg);
        ramp_next.up     = ACC_W'(mn_reg) + ACC_W'(ramp);
        ramp_next.down   = ACC_W'(mx_reg) - ACC_W'(ramp);
        ramp_next.sector = sector_reg;
        ramp_next.mx_pos = mx_pos_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            d_valid_reg <= 1'b0;
        end
        else if (d_ready)
        begin
            d_valid_reg <= c_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (d_ready && c_valid_reg)
        begin
            ramp_reg <= ramp_next;
        end
    end

    assign out_valid = d_valid_reg;
    assign out_ramp  = ramp_reg;

endmodule

FILE: hw/rtl/hsl_mix.sv
// ----------------------------------------------------------------------------
// hsl_mix: sector routing and output register
// Routes MX, MN and the ramp values to red, green and blue by hue sector,
// clamps each to 0..1.0 and holds the result for the downstream side.
// ----------------------------------------------------------------------------
module hsl_mix (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_ready,
    input  hsl_pkg::ramp_t in_ramp,
    output logic           out_valid,
    input  logic           out_ready,
    output hsl_pkg::rgb_t  out_rgb
);
    import hsl_pkg::*;

    logic                    e_valid_reg;
    rgb_t                    rgb_reg;
    rgb_t                    rgb_next;
    logic                    e_ready;
    logic signed [ACC_W-1:0] r_sel;
    logic signed [ACC_W-1:0] g_sel;
    logic signed [ACC_W-1:0] b_sel;

    assign e_ready  = !e_valid_reg || out_ready;
    assign in_ready = e_ready;

    // Sector routing; non-positive MX or a sector above six gives black, and sector six is routed like sector five
    always_comb
    begin
        r_sel = '0;
        g_sel = '0;
        b_sel = '0;
        if (in_ramp.mx_pos)
        begin
            case (in_ramp.sector) inside
                SEC_RED_GREEN_UP:
                begin
                    r_sel = in_ramp.mx;
                    g_sel = in_ramp.up;
                    b_sel = in_ramp.mn;
                end
                SEC_RED_DOWN:
                begin
                    r_sel = in_ramp.down;
                    g_sel = in_ramp.mx;
                    b_sel = in_ramp.mn;
                end
                SEC_BLUE_UP:
                begin
                    r_sel = in_ramp.mn;
                    g_sel = in_ramp.mx;
                    b_sel = in_ramp.up;
                end
                SEC_GREEN_DOWN:
                begin
                    r_sel = in_ramp.mn;
                    g_sel = in_ramp.down;
                    b_sel = in_ramp.mx;
                end
                SEC_RED_UP:
                begin
                    r_sel = in_ramp.up;
                    g_sel = in_ramp.mn;
                    b_sel = in_ramp.mx;
                end
                SEC_BLUE_DOWN, SEC_FULL_TURN:
                begin
                    r_sel = in_ramp.mx;
                    g_sel = in_ramp.mn;
                    b_sel = in_ramp.down;
                end
                default:
                begin
                    r_sel = '0;
                    g_sel = '0;
                    b_sel = '0;
                end
            endcase
        end
    end

    // Clamp to 0..1.0
    assign rgb_next.red   = sat_channel(r_sel);
    assign rgb_next.green = sat_channel(g_sel);
    assign rgb_next.blue  = sat_channel(b_sel);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            e_valid_reg <= 1'b0;
        end
        else if (e_ready)
        begin
            e_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (e_ready && in_valid)
        begin
            rgb_reg <= rgb_next;
        end
    end

    assign out_valid = e_valid_reg;
    assign out_rgb   = rgb_reg;

endmodule

FILE: hw/rtl/hsl_to_rgb_converter.sv
// HSL to RGB converter. Takes one pixel per clock while the output side does
// not stall and gives one result beat per pixel, in order. The five register
// stages are: L*S multiply, channel extremes, hue-fraction multiply, ramp
// scaling, sector routing and output register; the two multipliers set the
// stage depth. Each stage holds its beat under backpressure and takes a new
// one as soon as it has moved on, so the input keeps accepting until every
// stage is full. Input and output values are unsigned fixed point with 16
// fraction bits (65536 = 1.0); results are clamped to 0..65536.
// ----------------------------------------------------------------------------
// hsl_to_rgb_converter: top level
// Stream wrapper around the extreme, ramp and mix stages.
// ----------------------------------------------------------------------------
module hsl_to_rgb_converter (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [55:0] s_axis_tdata,   // hue[16:0], lightness[33:17], saturation[50:34]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [55:0] m_axis_tdata    // red[16:0], green[33:17], blue[50:34]
);
    import hsl_pkg::*;

    localparam int TDATA_W = 56;

    pix_t  in_pix;
    ext_t  ext;
    ramp_t ramp;
    rgb_t  rgb;
    logic  ext_valid;
    logic  ext_ready;
    logic  ramp_valid;
    logic  ramp_ready;

    // Unpack the input beat
    assign in_pix.hue        = s_axis_tdata[FIELD_W-1:0];
    assign in_pix.lightness  = s_axis_tdata[2*FIELD_W-1:FIELD_W];
    assign in_pix.saturation = s_axis_tdata[3*FIELD_W-1:2*FIELD_W];

    hsl_extreme u_extreme (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .in_pix    (in_pix),
        .out_valid (ext_valid),
        .out_ready (ext_ready),
        .out_ext   (ext)
    );

    hsl_ramp u_ramp (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (ext_valid),
        .in_ready  (ext_ready),
        .in_ext    (ext),
        .out_valid (ramp_valid),
        .out_ready (ramp_ready),
        .out_ramp  (ramp)
    );

    hsl_mix u_mix (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (ramp_valid),
        .in_ready  (ramp_ready),
        .in_ramp   (ramp),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_rgb   (rgb)
    );

    // Pack the output beat, zero fill to whole bytes
    assign m_axis_tdata = {(TDATA_W - 3*FIELD_W)'(0), rgb.blue, rgb.green, rgb.red};

    // An empty output register means no stage can be blocking the input
    a_ready_when_drained: assert property (
        @(posedge clk) disable iff (!rst_n)
        !m_axis_tvalid |-> s_axis_tready
    ) else $error("input stalled with empty output register");

    // Clamping keeps every channel within 0..1.0
    a_channels_clamped: assert property (
        @(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (m_axis_tdata[FIELD_W-1:0] <= ONE)
                       && (m_axis_tdata[2*FIELD_W-1:FIELD_W] <= ONE)
                       && (m_axis_tdata[3*FIELD_W-1:2*FIELD_W] <= ONE)
    ) else $error("output channel above 1.0");

    // Fill bits above the three channels stay zero in every output beat
    a_zero_pad: assert property (
        @(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (m_axis_tdata[TDATA_W-1:3*FIELD_W] == '0)
    ) else $error("padding bits set in output beat");

endmodule
